// File: rtl/sbq_pkg.sv
// sprite batch quad generator: shared constants, payload types and helpers
// no dependencies; compiled first
`timescale 1ns / 1ps

package sbq_pkg;

    localparam int MAX_QUADS     = 16384;
    localparam int TEXTURE_SLOTS = 32;

    localparam int IDX_STEP  = 6;
    localparam int IDX_LIMIT = MAX_QUADS * IDX_STEP;
    localparam int IDX_W     = $clog2(IDX_LIMIT + IDX_STEP);
    localparam int SLOT_W    = $clog2(TEXTURE_SLOTS);
    localparam int SCNT_W    = $clog2(TEXTURE_SLOTS + 1);

    localparam int NUM_ELEMS    = 9;
    localparam int NUM_ROWS     = 3;
    localparam int ELEM_W       = 32;
    localparam int TEX_W        = 16;
    localparam int TEX_SLOT_W   = 5;
    localparam int FLUSH_IDX_W  = 17;
    localparam int FLUSH_SLOT_W = 6;

    localparam logic [7:0] TILING_UNTEXTURED = 8'd1;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_DRAW  = 2'd2,
        CMD_END   = 2'd3
    } command_t;

    typedef enum logic {
        KIND_VERTEX = 1'b0,
        KIND_FLUSH  = 1'b1
    } kind_t;

    typedef struct packed {
        command_t            command;
        logic [3:0]          element_index;
        logic signed [31:0]  element_value;
        logic signed [31:0]  entity_id;
        logic [15:0]         texture_id;
        logic [31:0]         color_rgba;
        logic [7:0]          tiling_factor;
    } cmd_t;

    typedef struct packed {
        kind_t               kind;
        logic [1:0]          corner;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic [4:0]          tex_slot;
        logic [31:0]         vertex_color;
        logic [7:0]          vertex_tiling;
        logic signed [31:0]  vertex_entity;
        logic [16:0]         flush_index_count;
        logic [5:0]          flush_slot_count;
        logic                last;
    } res_t;

    // one row of the affine transform: x' = a*x + b*y + c
    typedef struct packed {
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic signed [ELEM_W-1:0] c;
    } xform_row_t;

    // corner signs applied by the coordinate unit
    typedef struct packed {
        logic neg_a;
        logic neg_b;
    } corner_sign_t;

    // element order m00,m01,m03,m10,m11,m13,m20,m21,m23
    function automatic logic [1:0] elem_row(input logic [3:0] idx);
        logic [1:0] row;
        case (idx)
            4'd0, 4'd1, 4'd2: row = 2'd0;
            4'd3, 4'd4, 4'd5: row = 2'd1;
            default:          row = 2'd2;
        endcase
        return row;
    endfunction

    function automatic logic [1:0] elem_col(input logic [3:0] idx);
        logic [1:0] col;
        case (idx)
            4'd0, 4'd3, 4'd6: col = 2'd0;
            4'd1, 4'd4, 4'd7: col = 2'd1;
            default:          col = 2'd2;
        endcase
        return col;
    endfunction

endpackage

// File: rtl/sbq_if.sv
// valid/ready channel interfaces for commands and results
// depends on sbq_pkg
`timescale 1ns / 1ps

interface sbq_cmd_if;
    logic          valid;
    logic          ready;
    sbq_pkg::cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sbq_res_if;
    logic          valid;
    logic          ready;
    sbq_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sbq_coord_alu.sv
// shared coordinate unit: floor((2c +- a +- b) / 2) saturated to 32 bits
// depends on sbq_pkg
`timescale 1ns / 1ps

module sbq_coord_alu (
    input  sbq_pkg::xform_row_t          row,
    input  sbq_pkg::corner_sign_t        sign,
    output logic signed [sbq_pkg::ELEM_W-1:0] coord
);
    import sbq_pkg::*;

    localparam int SUM_W = ELEM_W + 3;

    logic signed [SUM_W-1:0] ext_a;
    logic signed [SUM_W-1:0] ext_b;
    logic signed [SUM_W-1:0] ext_c2;
    logic signed [SUM_W-1:0] term_a;
    logic signed [SUM_W-1:0] term_b;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-2:0] half;
    logic                    fits;

    always_comb
    begin
        ext_a  = {{3{row.a[ELEM_W-1]}}, row.a};
        ext_b  = {{3{row.b[ELEM_W-1]}}, row.b};
        ext_c2 = {{2{row.c[ELEM_W-1]}}, row.c, 1'b0};
        term_a = sign.neg_a ? -ext_a : ext_a;
        term_b = sign.neg_b ? -ext_b : ext_b;
        sum    = ext_c2 + term_a + term_b;
        // arithmetic shift rounds toward minus infinity
        half   = sum[SUM_W-1:1];
        fits   = (half[SUM_W-2:ELEM_W-1] == '0) || (half[SUM_W-2:ELEM_W-1] == '1);
        if (fits)
        begin
            coord = half[ELEM_W-1:0];
        end
        else if (half[SUM_W-2])
        begin
            coord = {1'b1, {(ELEM_W-1){1'b0}}};
        end
        else
        begin
            coord = {1'b0, {(ELEM_W-1){1'b1}}};
        end
    end

endmodule

// File: rtl/sbq_slot_table.sv
// texture slot table: one write port, one read port with key compare
// depends on sbq_pkg
`timescale 1ns / 1ps

module sbq_slot_table (
    input  logic                        clk,
    input  logic                        we,
    input  logic [sbq_pkg::SLOT_W-1:0]  waddr,
    input  logic [sbq_pkg::TEX_W-1:0]   wdata,
    input  logic [sbq_pkg::SLOT_W-1:0]  raddr,
    input  logic [sbq_pkg::TEX_W-1:0]   key,
    output logic                        hit
);
    import sbq_pkg::*;

    logic [TEX_W-1:0] tex_reg [TEXTURE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tex_reg[waddr] <= wdata;
        end
    end

    assign hit = (tex_reg[raddr] == key);

endmodule

// File: rtl/sprite_batch_quad_generator_top.sv
// sprite batch quad generator: sequencer, transform store, batch counts
// depends on sbq_pkg, sbq_if, sbq_coord_alu, sbq_slot_table
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    sbq_pkg::cmd_t  (one command per transaction)
//   result   out  valid/ready    sbq_pkg::res_t  (vertex or flush record)
//
// begin batch and load transform are handled as the command is accepted; end
// scene waits for the result register to drain, then emits the final flush.
// a draw checks the budget, compares up to 31 slot entries, appends a texture
// on a miss, then computes and emits each corner; the single coordinate unit
// computes one coordinate per cycle (12 per sprite) while no stalled vertex
// holds it, and the slot table is searched one entry per cycle.
// after reset counts are index 0, slots 1 and the transform is all zero.
// a stalled result holds the sequencer wherever a record must be emitted.
`timescale 1ns / 1ps

module sprite_batch_quad_generator_top (
    input  logic         clk,
    input  logic         rst_n,
    sbq_cmd_if.sink      cmd,
    sbq_res_if.source    result
);
    import sbq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUDGET,
        S_SEARCH,
        S_APPEND,
        S_COORD,
        S_VERTEX,
        S_END
    } state_t;

    state_t                   state_reg;
    xform_row_t               xform_reg [NUM_ROWS];
    logic [SCNT_W-1:0]        slot_count_reg;
    logic [IDX_W-1:0]         index_count_reg;
    cmd_t                     draw_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [SCNT_W-1:0]        search_reg;
    logic [1:0]               corner_reg;
    logic [1:0]               sel_reg;
    logic signed [ELEM_W-1:0] pos_reg [NUM_ROWS];
    logic                     out_valid_reg;
    res_t                     out_reg;

    logic                     out_free;
    logic                     budget_full;
    logic                     slots_full;
    logic                     untextured;
    logic                     tbl_we;
    logic [SLOT_W-1:0]        tbl_waddr;
    logic                     tbl_hit;
    corner_sign_t             sign;
    logic signed [ELEM_W-1:0] coord;

    function automatic res_t flush_res(input logic [IDX_W-1:0] idx_cnt,
                                       input logic [SCNT_W-1:0] slot_cnt,
                                       input logic is_last);
        res_t r;
        r                   = '0;
        r.kind              = KIND_FLUSH;
        r.flush_index_count = FLUSH_IDX_W'(idx_cnt);
        r.flush_slot_count  = FLUSH_SLOT_W'(slot_cnt);
        r.last              = is_last;
        return r;
    endfunction

    assign out_free    = !out_valid_reg || result.ready;
    assign budget_full = (index_count_reg >= IDX_W'(IDX_LIMIT));
    assign slots_full  = (slot_count_reg >= SCNT_W'(TEXTURE_SLOTS));
    assign untextured  = (draw_reg.texture_id == '0);

    // append writes slot 1 after a forced flush, else the next free slot
    assign tbl_we    = (state_reg == S_APPEND) && (!slots_full || out_free);
    assign tbl_waddr = slots_full ? SLOT_W'(1) : slot_count_reg[SLOT_W-1:0];

    sbq_slot_table u_slot_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (draw_reg.texture_id),
        .raddr (search_reg[SLOT_W-1:0]),
        .key   (draw_reg.texture_id),
        .hit   (tbl_hit)
    );

    // corner order (-,-), (+,-), (+,+), (-,+)
    assign sign.neg_a = (corner_reg == 2'd0) || (corner_reg == 2'd3);
    assign sign.neg_b = (corner_reg == 2'd0) || (corner_reg == 2'd1);

    sbq_coord_alu u_coord_alu (
        .row   (xform_reg[sel_reg]),
        .sign  (sign),
        .coord (coord)
    );

    assign cmd.ready    = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slot_count_reg  <= SCNT_W'(1);
            index_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                xform_reg[r] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        unique case (cmd.data.command)
                            CMD_BEGIN:
                            begin
                                index_count_reg <= '0;
                                slot_count_reg  <= SCNT_W'(1);
                            end
                            CMD_LOAD:
                            begin
                                if (cmd.data.element_index < 4'(NUM_ELEMS))
                                begin
                                    case (elem_col(cmd.data.element_index))
                                        2'd0:
                                            xform_reg[elem_row(cmd.data.element_index)].a
                                                <= cmd.data.element_value;
                                        2'd1:
                                            xform_reg[elem_row(cmd.data.element_index)].b
                                                <= cmd.data.element_value;
                                        default:
                                            xform_reg[elem_row(cmd.data.element_index)].c
                                                <= cmd.data.element_value;
                                    endcase
                                end
                            end
                            CMD_DRAW:
                            begin
                                draw_reg  <= cmd.data;
                                state_reg <= S_BUDGET;
                            end
                            CMD_END:
                            begin
                                state_reg <= S_END;
                            end
                        endcase
                    end
                end

                S_BUDGET:
                begin
                    if (!budget_full || out_free)
                    begin
                        if (budget_full)
                        begin
                            out_reg         <= flush_res(index_count_reg, slot_count_reg, 1'b0);
                            out_valid_reg   <= 1'b1;
                            index_count_reg <= '0;
                            slot_count_reg  <= SCNT_W'(1);
                        end
                        slot_reg   <= '0;
                        search_reg <= SCNT_W'(1);
                        corner_reg <= '0;
                        sel_reg    <= '0;
                        state_reg  <= untextured ? S_COORD : S_SEARCH;
                    end
                end

                S_SEARCH:
                begin
                    if (search_reg < slot_count_reg)
                    begin
                        if (tbl_hit)
                        begin
                            slot_reg  <= search_reg[SLOT_W-1:0];
                            state_reg <= S_COORD;
                        end
                        else
                        begin
                            search_reg <= search_reg + SCNT_W'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= S_APPEND;
                    end
                end

                S_APPEND:
                begin
                    if (slots_full)
                    begin
                        if (out_free)
                        begin
                            out_reg         <= flush_res(index_count_reg, slot_count_reg, 1'b0);
                            out_valid_reg   <= 1'b1;
                            index_count_reg <= '0;
                            slot_count_reg  <= SCNT_W'(2);
                            slot_reg        <= SLOT_W'(1);
                            state_reg       <= S_COORD;
                        end
                    end
                    else
                    begin
                        slot_reg       <= slot_count_reg[SLOT_W-1:0];
                        slot_count_reg <= slot_count_reg + SCNT_W'(1);
                        state_reg      <= S_COORD;
                    end
                end

                S_COORD:
                begin
                    pos_reg[sel_reg] <= coord;
                    if (sel_reg == 2'd2)
                    begin
                        sel_reg   <= '0;
                        state_reg <= S_VERTEX;
                    end
                    else
                    begin
                        sel_reg <= sel_reg + 2'd1;
                    end
                end

                S_VERTEX:
                begin
                    if (out_free)
                    begin
                        out_reg.kind              <= KIND_VERTEX;
                        out_reg.corner            <= corner_reg;
                        out_reg.pos_x             <= pos_reg[0];
                        out_reg.pos_y             <= pos_reg[1];
                        out_reg.pos_z             <= pos_reg[2];
                        out_reg.tex_slot          <= TEX_SLOT_W'(slot_reg);
                        out_reg.vertex_color      <= draw_reg.color_rgba;
                        out_reg.vertex_tiling     <= untextured ? TILING_UNTEXTURED
                                                                : draw_reg.tiling_factor;
                        out_reg.vertex_entity     <= draw_reg.entity_id;
                        out_reg.flush_index_count <= '0;
                        out_reg.flush_slot_count  <= '0;
                        out_reg.last              <= (corner_reg == 2'd3);
                        out_valid_reg             <= 1'b1;
                        if (corner_reg == 2'd3)
                        begin
                            index_count_reg <= index_count_reg + IDX_W'(IDX_STEP);
                            state_reg       <= S_IDLE;
                        end
                        else
                        begin
                            corner_reg <= corner_reg + 2'd1;
                            state_reg  <= S_COORD;
                        end
                    end
                end

                S_END:
                begin
                    if (out_free)
                    begin
                        out_reg       <= flush_res(index_count_reg, slot_count_reg, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // slot count always covers the white slot and never exceeds the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (slot_count_reg >= SCNT_W'(1)) && (slot_count_reg <= SCNT_W'(TEXTURE_SLOTS)))
        else $error("slot count out of range");

    // index budget check keeps the count at or below the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        index_count_reg <= IDX_W'(IDX_LIMIT))
        else $error("index count beyond budget");

    // a vertex closes the draw exactly on the fourth corner
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.data.kind == KIND_VERTEX))
            |-> (result.data.last == (result.data.corner == 2'd3)))
        else $error("vertex last flag does not match corner");

    // a draw holds off further commands while it runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && (cmd.data.command == CMD_DRAW)) |=> !cmd.ready)
        else $error("command accepted during a draw");

    // the coordinate unit only ever addresses the three transform rows
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COORD) |-> (sel_reg != 2'd3))
        else $error("transform row select out of range");
`endif

endmodule
